/* rtl/core/hid2ps2_pkg.sv */
package hid2ps2_pkg;

    // Usage IDs at or above this bound are reported as out of range.
    localparam int KEY_TABLE_SIZE = 232;

    // Depth of the request queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Longest byte sequence one key event can produce.
    localparam int MAX_BYTES = 8;
    localparam int IDX_W     = $clog2(MAX_BYTES);
    localparam int LEN_W     = $clog2(MAX_BYTES + 1);

    // Scan code set 2 bytes with a fixed meaning.
    localparam logic [7:0] BYTE_BREAK     = 8'hF0;
    localparam logic [7:0] BYTE_EXT       = 8'hE0;
    localparam logic [7:0] BYTE_EXT1      = 8'hE1;
    localparam logic [7:0] BYTE_LSHIFT    = 8'h12;
    localparam logic [7:0] BYTE_SYSRQ     = 8'h84;
    localparam logic [7:0] BYTE_PRTSCR    = 8'h7C;
    localparam logic [7:0] BYTE_LCTRL     = 8'h14;
    localparam logic [7:0] BYTE_NUMLOCK   = 8'h77;
    localparam logic [7:0] BYTE_SCROLL    = 8'h7E;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOMAP = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // How a usage is translated.
    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_PLAIN  = 3'd1,
        KIND_EXT    = 3'd2,
        KIND_NAV    = 3'd3,
        KIND_PRTSCR = 3'd4,
        KIND_PAUSE  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
    } t_map;

    // One translated event as it travels from the front part to the back part.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] seq;
        logic [IDX_W-1:0]          last_idx;
        t_status                   status;
    } t_desc;

    function automatic t_map mk(input t_kind kind, input logic [7:0] code);
        t_map m;
        m.kind = kind;
        m.code = code;
        return m;
    endfunction

    // Usage ID to scan code lookup.
    function automatic t_map key_map(input logic [7:0] usage);
        t_map m;
        case (usage)
            8'h04: m = mk(KIND_PLAIN, 8'h1C);  8'h05: m = mk(KIND_PLAIN, 8'h32);
            8'h06: m = mk(KIND_PLAIN, 8'h21);  8'h07: m = mk(KIND_PLAIN, 8'h23);
            8'h08: m = mk(KIND_PLAIN, 8'h24);  8'h09: m = mk(KIND_PLAIN, 8'h2B);
            8'h0A: m = mk(KIND_PLAIN, 8'h34);  8'h0B: m = mk(KIND_PLAIN, 8'h33);
            8'h0C: m = mk(KIND_PLAIN, 8'h43);  8'h0D: m = mk(KIND_PLAIN, 8'h3B);
            8'h0E: m = mk(KIND_PLAIN, 8'h42);  8'h0F: m = mk(KIND_PLAIN, 8'h4B);
            8'h10: m = mk(KIND_PLAIN, 8'h3A);  8'h11: m = mk(KIND_PLAIN, 8'h31);
            8'h12: m = mk(KIND_PLAIN, 8'h44);  8'h13: m = mk(KIND_PLAIN, 8'h4D);
            8'h14: m = mk(KIND_PLAIN, 8'h15);  8'h15: m = mk(KIND_PLAIN, 8'h2D);
            8'h16: m = mk(KIND_PLAIN, 8'h1B);  8'h17: m = mk(KIND_PLAIN, 8'h2C);
            8'h18: m = mk(KIND_PLAIN, 8'h3C);  8'h19: m = mk(KIND_PLAIN, 8'h2A);
            8'h1A: m = mk(KIND_PLAIN, 8'h1D);  8'h1B: m = mk(KIND_PLAIN, 8'h22);
            8'h1C: m = mk(KIND_PLAIN, 8'h35);  8'h1D: m = mk(KIND_PLAIN, 8'h1A);
            8'h1E: m = mk(KIND_PLAIN, 8'h16);  8'h1F: m = mk(KIND_PLAIN, 8'h1E);
            8'h20: m = mk(KIND_PLAIN, 8'h26);  8'h21: m = mk(KIND_PLAIN, 8'h25);
            8'h22: m = mk(KIND_PLAIN, 8'h2E);  8'h23: m = mk(KIND_PLAIN, 8'h36);
            8'h24: m = mk(KIND_PLAIN, 8'h3D);  8'h25: m = mk(KIND_PLAIN, 8'h3E);
            8'h26: m = mk(KIND_PLAIN, 8'h46);  8'h27: m = mk(KIND_PLAIN, 8'h45);
            8'h28: m = mk(KIND_PLAIN, 8'h5A);  8'h29: m = mk(KIND_PLAIN, 8'h76);
            8'h2A: m = mk(KIND_PLAIN, 8'h66);  8'h2B: m = mk(KIND_PLAIN, 8'h0D);
            8'h2C: m = mk(KIND_PLAIN, 8'h29);  8'h2D: m = mk(KIND_PLAIN, 8'h4E);
            8'h2E: m = mk(KIND_PLAIN, 8'h55);  8'h2F: m = mk(KIND_PLAIN, 8'h54);
            8'h30: m = mk(KIND_PLAIN, 8'h5B);  8'h31: m = mk(KIND_PLAIN, 8'h5D);
            8'h32: m = mk(KIND_PLAIN, 8'h5D);  8'h33: m = mk(KIND_PLAIN, 8'h4C);
            8'h34: m = mk(KIND_PLAIN, 8'h52);  8'h35: m = mk(KIND_PLAIN, 8'h0E);
            8'h36: m = mk(KIND_PLAIN, 8'h41);  8'h37: m = mk(KIND_PLAIN, 8'h49);
            8'h38: m = mk(KIND_PLAIN, 8'h4A);  8'h39: m = mk(KIND_PLAIN, 8'h58);
            8'h3A: m = mk(KIND_PLAIN, 8'h05);  8'h3B: m = mk(KIND_PLAIN, 8'h06);
            8'h3C: m = mk(KIND_PLAIN, 8'h04);  8'h3D: m = mk(KIND_PLAIN, 8'h0C);
            8'h3E: m = mk(KIND_PLAIN, 8'h03);  8'h3F: m = mk(KIND_PLAIN, 8'h0B);
            8'h40: m = mk(KIND_PLAIN, 8'h83);  8'h41: m = mk(KIND_PLAIN, 8'h0A);
            8'h42: m = mk(KIND_PLAIN, 8'h01);  8'h43: m = mk(KIND_PLAIN, 8'h09);
            8'h44: m = mk(KIND_PLAIN, 8'h78);  8'h45: m = mk(KIND_PLAIN, 8'h07);
            8'h46: m = mk(KIND_PRTSCR, 8'h00); 8'h47: m = mk(KIND_PLAIN, 8'h7E);
            8'h48: m = mk(KIND_PAUSE, 8'h00);
            8'h49: m = mk(KIND_NAV, 8'h70);    8'h4A: m = mk(KIND_NAV, 8'h6C);
            8'h4B: m = mk(KIND_NAV, 8'h7D);    8'h4C: m = mk(KIND_NAV, 8'h71);
            8'h4D: m = mk(KIND_NAV, 8'h69);    8'h4E: m = mk(KIND_NAV, 8'h7A);
            8'h4F: m = mk(KIND_NAV, 8'h74);    8'h50: m = mk(KIND_NAV, 8'h6B);
            8'h51: m = mk(KIND_NAV, 8'h72);    8'h52: m = mk(KIND_NAV, 8'h75);
            8'h53: m = mk(KIND_PLAIN, 8'h77);  8'h54: m = mk(KIND_NAV, 8'h4A);
            8'h55: m = mk(KIND_PLAIN, 8'h7C);  8'h56: m = mk(KIND_PLAIN, 8'h7B);
            8'h57: m = mk(KIND_PLAIN, 8'h79);  8'h58: m = mk(KIND_EXT, 8'h5A);
            8'h59: m = mk(KIND_PLAIN, 8'h69);  8'h5A: m = mk(KIND_PLAIN, 8'h72);
            8'h5B: m = mk(KIND_PLAIN, 8'h7A);  8'h5C: m = mk(KIND_PLAIN, 8'h6B);
            8'h5D: m = mk(KIND_PLAIN, 8'h73);  8'h5E: m = mk(KIND_PLAIN, 8'h74);
            8'h5F: m = mk(KIND_PLAIN, 8'h6C);  8'h60: m = mk(KIND_PLAIN, 8'h75);
            8'h61: m = mk(KIND_PLAIN, 8'h7D);  8'h62: m = mk(KIND_PLAIN, 8'h70);
            8'h63: m = mk(KIND_PLAIN, 8'h71);  8'h64: m = mk(KIND_PLAIN, 8'h61);
            8'h65: m = mk(KIND_EXT, 8'h2F);
            8'h7F: m = mk(KIND_EXT, 8'h23);    8'h80: m = mk(KIND_EXT, 8'h32);
            8'h81: m = mk(KIND_EXT, 8'h21);
            8'h9A: m = mk(KIND_PRTSCR, 8'h00);
            8'hE0: m = mk(KIND_PLAIN, 8'h14);  8'hE1: m = mk(KIND_PLAIN, 8'h12);
            8'hE2: m = mk(KIND_PLAIN, 8'h11);  8'hE3: m = mk(KIND_EXT, 8'h1F);
            8'hE4: m = mk(KIND_EXT, 8'h14);    8'hE5: m = mk(KIND_PLAIN, 8'h59);
            8'hE6: m = mk(KIND_EXT, 8'h11);    8'hE7: m = mk(KIND_EXT, 8'h27);
            default: m = mk(KIND_NONE, 8'h00);
        endcase
        return m;
    endfunction

endpackage

/* rtl/core/hid_usage_to_ps2_set2_scancode.sv */
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: key and flags, tuser: make or break
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: scan byte, tuser: status, tlast
//
// A key event yields one to eight output bytes, one per cycle while m_axis_tready is high;
// the back part's byte sequencer emits them in order.
// A new event is accepted every cycle while the two-entry request queue has room.
// Events pass through the queue, the request register and the output register.
// Reset is synchronous and active low; it empties the queue and the output register.
module hid_usage_to_ps2_set2_scancode
    import hid2ps2_pkg::*;
#(
    parameter int KEY_TABLE_SIZE = hid2ps2_pkg::KEY_TABLE_SIZE
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // key_usage[7:0], ctrl_held, shift_held, alt_held,
                                        // num_lock_on, auto_repeat, zero pad
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // scan_byte[7:0]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast    // last_byte
);

    t_desc   w_front_desc;
    t_desc   w_q_desc;
    logic    w_q_full;
    logic    w_q_valid;
    logic    w_pop;
    logic    w_push;
    t_status w_status;

    assign s_axis_tready = !w_q_full;
    assign w_push        = s_axis_tvalid && !w_q_full;

    // Classify the event into its byte sequence.
    hid2ps2_front #(
        .KEY_TABLE_SIZE (KEY_TABLE_SIZE)
    ) u_front (
        .i_brk      (s_axis_tuser),
        .i_usage    (s_axis_tdata[7:0]),
        .i_ctrl     (s_axis_tdata[8]),
        .i_shift    (s_axis_tdata[9]),
        .i_alt      (s_axis_tdata[10]),
        .i_num_lock (s_axis_tdata[11]),
        .i_repeat   (s_axis_tdata[12]),
        .o_desc     (w_front_desc)
    );

    // Request queue between the two parts.
    hid2ps2_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_front_desc),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_desc  (w_q_desc)
    );

    // Emit the bytes one at a time.
    hid2ps2_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_desc    (w_q_desc),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_status  (w_status)
    );

    assign m_axis_tuser = w_status;

endmodule

/* rtl/core/hid2ps2_front.sv */
module hid2ps2_front
    import hid2ps2_pkg::*;
#(
    parameter int KEY_TABLE_SIZE = hid2ps2_pkg::KEY_TABLE_SIZE
)
(
    input  logic       i_brk,
    input  logic [7:0] i_usage,
    input  logic       i_ctrl,
    input  logic       i_shift,
    input  logic       i_alt,
    input  logic       i_num_lock,
    input  logic       i_repeat,
    output t_desc      o_desc
);

    t_map               w_map;
    logic               w_in_range;
    logic [7:0]         w_code;
    logic [LEN_W-1:0]   w_len;
    logic [MAX_BYTES-1:0][7:0] w_seq;

    // Look the usage up and check it against the table bound.
    assign w_map      = key_map(i_usage);
    assign w_code     = w_map.code;
    assign w_in_range = ({1'b0, i_usage} < 9'(KEY_TABLE_SIZE));

    // Build the byte sequence for this event.
    always_comb begin
        w_seq = '0;
        w_len = '0;
        case (w_map.kind)
            KIND_PLAIN: begin
                if (i_brk) begin
                    w_seq[0] = BYTE_BREAK;
                    w_seq[1] = w_code;
                    w_len    = LEN_W'(2);
                end else begin
                    w_seq[0] = w_code;
                    w_len    = LEN_W'(1);
                end
            end
            KIND_EXT: begin
                w_seq[0] = BYTE_EXT;
                if (i_brk) begin
                    w_seq[1] = BYTE_BREAK;
                    w_seq[2] = w_code;
                    w_len    = LEN_W'(3);
                end else begin
                    w_seq[1] = w_code;
                    w_len    = LEN_W'(2);
                end
            end
            KIND_NAV: begin
                w_seq[0] = BYTE_EXT;
                if (!i_brk) begin
                    // Fake shift: undo Shift, or add it under Num Lock.
                    if (i_shift && !i_num_lock && !i_repeat) begin
                        w_seq[1] = BYTE_BREAK;
                        w_seq[2] = BYTE_LSHIFT;
                        w_seq[3] = BYTE_EXT;
                        w_seq[4] = w_code;
                        w_len    = LEN_W'(5);
                    end else if (!i_shift && i_num_lock && !i_repeat) begin
                        w_seq[1] = BYTE_LSHIFT;
                        w_seq[2] = BYTE_EXT;
                        w_seq[3] = w_code;
                        w_len    = LEN_W'(4);
                    end else begin
                        w_seq[1] = w_code;
                        w_len    = LEN_W'(2);
                    end
                end else begin
                    w_seq[1] = BYTE_BREAK;
                    w_seq[2] = w_code;
                    w_len    = LEN_W'(3);
                    if (i_shift && !i_num_lock) begin
                        w_seq[3] = BYTE_EXT;
                        w_seq[4] = BYTE_LSHIFT;
                        w_len    = LEN_W'(5);
                    end else if (!i_shift && i_num_lock) begin
                        w_seq[3] = BYTE_EXT;
                        w_seq[4] = BYTE_BREAK;
                        w_seq[5] = BYTE_LSHIFT;
                        w_len    = LEN_W'(6);
                    end
                end
            end
            KIND_PRTSCR: begin
                if (i_alt) begin
                    // SysRq.
                    if (i_brk) begin
                        w_seq[0] = BYTE_BREAK;
                        w_seq[1] = BYTE_SYSRQ;
                        w_len    = LEN_W'(2);
                    end else begin
                        w_seq[0] = BYTE_SYSRQ;
                        w_len    = LEN_W'(1);
                    end
                end else if (!i_brk) begin
                    if (!(i_ctrl || i_shift)) begin
                        w_seq[0] = BYTE_EXT;
                        w_seq[1] = BYTE_LSHIFT;
                        w_seq[2] = BYTE_EXT;
                        w_seq[3] = BYTE_PRTSCR;
                        w_len    = LEN_W'(4);
                    end else begin
                        w_seq[0] = BYTE_EXT;
                        w_seq[1] = BYTE_PRTSCR;
                        w_len    = LEN_W'(2);
                    end
                end else begin
                    w_seq[0] = BYTE_EXT;
                    w_seq[1] = BYTE_BREAK;
                    w_seq[2] = BYTE_PRTSCR;
                    w_len    = LEN_W'(3);
                    if (!(i_ctrl || i_shift)) begin
                        w_seq[3] = BYTE_EXT;
                        w_seq[4] = BYTE_BREAK;
                        w_seq[5] = BYTE_LSHIFT;
                        w_len    = LEN_W'(6);
                    end
                end
            end
            KIND_PAUSE: begin
                // Pause has no break sequence at all.
                if (!i_brk) begin
                    if (i_ctrl) begin
                        w_seq[0] = BYTE_EXT;
                        w_seq[1] = BYTE_SCROLL;
                        w_seq[2] = BYTE_EXT;
                        w_seq[3] = BYTE_BREAK;
                        w_seq[4] = BYTE_SCROLL;
                        w_len    = LEN_W'(5);
                    end else begin
                        w_seq[0] = BYTE_EXT1;
                        w_seq[1] = BYTE_LCTRL;
                        w_seq[2] = BYTE_NUMLOCK;
                        w_seq[3] = BYTE_EXT1;
                        w_seq[4] = BYTE_BREAK;
                        w_seq[5] = BYTE_LCTRL;
                        w_seq[6] = BYTE_BREAK;
                        w_seq[7] = BYTE_NUMLOCK;
                        w_len    = LEN_W'(8);
                    end
                end
            end
            default: begin
                w_len = '0;
            end
        endcase
    end

    // Out of range and empty sequences collapse to a single status result.
    always_comb begin
        o_desc = '0;
        if (!w_in_range) begin
            o_desc.status = ST_RANGE;
        end else if (w_len == '0) begin
            o_desc.status = ST_NOMAP;
        end else begin
            o_desc.seq      = w_seq;
            o_desc.last_idx = IDX_W'(w_len - LEN_W'(1));
            o_desc.status   = ST_OK;
        end
    end

endmodule

/* rtl/core/hid2ps2_queue.sv */
module hid2ps2_queue
    import hid2ps2_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    t_desc                  r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_entry[r_rd_ptr];

    // Pointer wrap at the queue depth.
    always_comb begin
        n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/hid2ps2_back.sv */
module hid2ps2_back
    import hid2ps2_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_desc      i_desc,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last,
    output t_status    o_status
);

    t_desc            r_cur;
    logic             r_cur_valid;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    t_status          r_out_status;

    logic             w_adv;
    logic             w_emit;
    logic             w_at_last;
    logic             w_free;

    // The output register moves when it is empty or being taken.
    assign w_adv     = !r_out_valid || i_ready;
    assign w_emit    = r_cur_valid && w_adv;
    assign w_at_last = (r_idx == r_cur.last_idx);
    assign w_free    = !r_cur_valid || (w_emit && w_at_last);
    assign o_pop     = i_q_valid && w_free;

    // Current request and byte index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= '0;
        end else if (o_pop) begin
            r_cur_valid <= 1'b1;
            r_idx       <= '0;
        end else if (w_emit && w_at_last) begin
            r_cur_valid <= 1'b0;
        end else if (w_emit) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_desc;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_cur_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte   <= r_cur.seq[r_idx];
            r_out_last   <= w_at_last;
            r_out_status <= r_cur.status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_byte   = r_out_byte;
    assign o_last   = r_out_last;
    assign o_status = r_out_status;

endmodule

/* dv/hid_usage_to_ps2_set2_scancode_tb.sv */
`timescale 1ns / 1ps

module hid_usage_to_ps2_set2_scancode_tb;
    import hid2ps2_pkg::*;

    // One key event as the sender sees it.
    typedef struct packed {
        logic       is_release;
        logic [7:0] usage;
        logic       ctrl;
        logic       shift;
        logic       alt;
        logic       num_lock;
        logic       typematic;
    } t_key_event;

    // One scan code byte as it should leave the block.
    typedef struct packed {
        logic [7:0] scan_byte;
        logic       last_byte;
        t_status    status;
    } t_scan_result;

    // Scan codes of the main block, usages 0x04 to 0x45, in usage order.
    localparam logic [0:65][7:0] MAIN_BLOCK_CODES = {
        8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B, 8'h42,
        8'h4B, 8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C, 8'h3C, 8'h2A,
        8'h1D, 8'h22, 8'h35, 8'h1A, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D,
        8'h3E, 8'h46, 8'h45, 8'h5A, 8'h76, 8'h66, 8'h0D, 8'h29, 8'h4E, 8'h55, 8'h54,
        8'h5B, 8'h5D, 8'h5D, 8'h4C, 8'h52, 8'h0E, 8'h41, 8'h49, 8'h4A, 8'h58, 8'h05,
        8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B, 8'h83, 8'h0A, 8'h01, 8'h09, 8'h78, 8'h07
    };
    // Navigation block, usages 0x49 to 0x52.
    localparam logic [0:9][7:0] NAV_BLOCK_CODES = {
        8'h70, 8'h6C, 8'h7D, 8'h71, 8'h69, 8'h7A, 8'h74, 8'h6B, 8'h72, 8'h75
    };
    // Keypad, usages 0x55 to 0x64; Enter at 0x58 is extended.
    localparam logic [0:15][7:0] KEYPAD_CODES = {
        8'h7C, 8'h7B, 8'h79, 8'h5A, 8'h69, 8'h72, 8'h7A, 8'h6B, 8'h73, 8'h74, 8'h6C,
        8'h75, 8'h7D, 8'h70, 8'h71, 8'h61
    };
    // Modifier keys, usages 0xE0 to 0xE7; both GUI keys and the right-hand Ctrl and Alt are extended.
    localparam logic [0:7][7:0] MODIFIER_CODES = {
        8'h14, 8'h12, 8'h11, 8'h1F, 8'h14, 8'h59, 8'h11, 8'h27
    };
    localparam logic [0:7] MODIFIER_IS_EXT = 8'b00011011;
    // Usages with flag-dependent sequences, plus a few boundary keys.
    localparam logic [0:15][7:0] SPECIAL_USAGES = {
        8'h46, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51,
        8'h52, 8'h54, 8'h9A, 8'h58, 8'hE7
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;   // key_usage[7:0], ctrl_held, shift_held,
                                            // alt_held, num_lock_on, auto_repeat, zero pad
    logic        s_axis_tuser = 1'b0;       // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;              // scan_byte[7:0]
    logic [1:0]  m_axis_tuser;              // status[1:0]
    logic        m_axis_tlast;              // last_byte

    t_kind        usage_kind [256];
    logic [7:0]   usage_code [256];
    t_scan_result expected_scan_q [$];
    int           error_count = 0;
    bit           send_gaps = 1'b1;
    bit           recv_gaps = 1'b1;
    int           holdoff_trigger = 0;

    hid_usage_to_ps2_set2_scancode dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Fill the usage lookup from the code blocks above.
    function automatic void load_usage_table();
        for (int u = 0; u < 256; u++) begin
            usage_kind[u] = KIND_NONE;
            usage_code[u] = 8'h00;
        end
        for (int u = 0; u < 66; u++) begin
            usage_kind[8'h04 + u] = KIND_PLAIN;
            usage_code[8'h04 + u] = MAIN_BLOCK_CODES[u];
        end
        for (int u = 0; u < 10; u++) begin
            usage_kind[8'h49 + u] = KIND_NAV;
            usage_code[8'h49 + u] = NAV_BLOCK_CODES[u];
        end
        for (int u = 0; u < 16; u++) begin
            usage_kind[8'h55 + u] = KIND_PLAIN;
            usage_code[8'h55 + u] = KEYPAD_CODES[u];
        end
        for (int u = 0; u < 8; u++) begin
            usage_kind[8'hE0 + u] = MODIFIER_IS_EXT[u] ? KIND_EXT : KIND_PLAIN;
            usage_code[8'hE0 + u] = MODIFIER_CODES[u];
        end
        usage_kind[8'h58] = KIND_EXT;
        usage_kind[8'h46] = KIND_PRTSCR;
        usage_kind[8'h9A] = KIND_PRTSCR;
        usage_kind[8'h48] = KIND_PAUSE;
        usage_kind[8'h47] = KIND_PLAIN;  usage_code[8'h47] = 8'h7E;
        usage_kind[8'h53] = KIND_PLAIN;  usage_code[8'h53] = 8'h77;
        usage_kind[8'h54] = KIND_NAV;    usage_code[8'h54] = 8'h4A;
        usage_kind[8'h65] = KIND_EXT;    usage_code[8'h65] = 8'h2F;
        usage_kind[8'h7F] = KIND_EXT;    usage_code[8'h7F] = 8'h23;
        usage_kind[8'h80] = KIND_EXT;    usage_code[8'h80] = 8'h32;
        usage_kind[8'h81] = KIND_EXT;    usage_code[8'h81] = 8'h21;
    endfunction

    // Work out the scan code bytes of one key event and queue them.
    function automatic void predict_scan_bytes(input t_key_event ev);
        logic [7:0]   seq [$];
        t_kind        kind;
        logic [7:0]   code;
        t_scan_result res;
        if (ev.usage >= KEY_TABLE_SIZE) begin
            res = '{scan_byte: 8'h00, last_byte: 1'b1, status: ST_RANGE};
            expected_scan_q.push_back(res);
            return;
        end
        kind = usage_kind[ev.usage];
        code = usage_code[ev.usage];
        case (kind)
            KIND_PLAIN: begin
                if (ev.is_release) seq.push_back(BYTE_BREAK);
                seq.push_back(code);
            end
            KIND_EXT: begin
                seq.push_back(BYTE_EXT);
                if (ev.is_release) seq.push_back(BYTE_BREAK);
                seq.push_back(code);
            end
            // Navigation keys carry a fake shift that undoes Shift or applies Num Lock.
            KIND_NAV: begin
                if (!ev.is_release) begin
                    if (ev.shift && !ev.num_lock && !ev.typematic) begin
                        seq.push_back(BYTE_EXT); seq.push_back(BYTE_BREAK);
                        seq.push_back(BYTE_LSHIFT);
                    end else if (!ev.shift && ev.num_lock && !ev.typematic) begin
                        seq.push_back(BYTE_EXT); seq.push_back(BYTE_LSHIFT);
                    end
                    seq.push_back(BYTE_EXT); seq.push_back(code);
                end else begin
                    seq.push_back(BYTE_EXT); seq.push_back(BYTE_BREAK); seq.push_back(code);
                    if (ev.shift && !ev.num_lock) begin
                        seq.push_back(BYTE_EXT); seq.push_back(BYTE_LSHIFT);
                    end else if (!ev.shift && ev.num_lock) begin
                        seq.push_back(BYTE_EXT); seq.push_back(BYTE_BREAK);
                        seq.push_back(BYTE_LSHIFT);
                    end
                end
            end
            // Print Screen turns into SysRq with Alt and drops the fake shift with Ctrl or Shift.
            KIND_PRTSCR: begin
                if (ev.alt) begin
                    if (ev.is_release) seq.push_back(BYTE_BREAK);
                    seq.push_back(BYTE_SYSRQ);
                end else if (!ev.is_release) begin
                    if (!(ev.ctrl || ev.shift)) begin
                        seq.push_back(BYTE_EXT); seq.push_back(BYTE_LSHIFT);
                    end
                    seq.push_back(BYTE_EXT); seq.push_back(BYTE_PRTSCR);
                end else begin
                    seq.push_back(BYTE_EXT); seq.push_back(BYTE_BREAK);
                    seq.push_back(BYTE_PRTSCR);
                    if (!(ev.ctrl || ev.shift)) begin
                        seq.push_back(BYTE_EXT); seq.push_back(BYTE_BREAK);
                        seq.push_back(BYTE_LSHIFT);
                    end
                end
            end
            // Pause sends make and break together on press; Ctrl makes it Break.
            KIND_PAUSE: begin
                if (!ev.is_release) begin
                    if (ev.ctrl) begin
                        seq.push_back(BYTE_EXT); seq.push_back(BYTE_SCROLL);
                        seq.push_back(BYTE_EXT); seq.push_back(BYTE_BREAK);
                        seq.push_back(BYTE_SCROLL);
                    end else begin
                        seq.push_back(BYTE_EXT1); seq.push_back(BYTE_LCTRL);
                        seq.push_back(BYTE_NUMLOCK); seq.push_back(BYTE_EXT1);
                        seq.push_back(BYTE_BREAK); seq.push_back(BYTE_LCTRL);
                        seq.push_back(BYTE_BREAK); seq.push_back(BYTE_NUMLOCK);
                    end
                end
            end
            default: ;
        endcase
        // An empty sequence is reported as a key without a code.
        if (seq.size() == 0) begin
            res = '{scan_byte: 8'h00, last_byte: 1'b1, status: ST_NOMAP};
            expected_scan_q.push_back(res);
        end else begin
            foreach (seq[i]) begin
                res = '{scan_byte: seq[i], last_byte: (i == seq.size() - 1), status: ST_OK};
                expected_scan_q.push_back(res);
            end
        end
    endfunction

    function automatic t_key_event key_event(input bit rel, input logic [7:0] usage,
                                             input bit ctrl, input bit shift, input bit alt,
                                             input bit num_lock, input bit typematic);
        t_key_event ev;
        ev = '{is_release: rel, usage: usage, ctrl: ctrl, shift: shift, alt: alt,
               num_lock: num_lock, typematic: typematic};
        return ev;
    endfunction

    // Random key event, biased toward the keys whose sequences depend on the flags.
    function automatic t_key_event random_key_event();
        logic [7:0] usage;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 35)
            usage = SPECIAL_USAGES[$urandom_range(15)];
        else if (pick < 85)
            usage = 8'($urandom_range(KEY_TABLE_SIZE - 1));
        else
            usage = 8'($urandom_range(255));
        return key_event(1'($urandom_range(1)), usage, 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    // Offer one key event request and wait until it is accepted. Starts and ends at a clock edge.
    task automatic send_key_event(input t_key_event ev);
        int gap;
        bit accepted;
        gap = (send_gaps && $urandom_range(99) < 28) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {3'b000, ev.typematic, ev.num_lock, ev.alt, ev.shift, ev.ctrl,
                          ev.usage};
        s_axis_tuser  <= ev.is_release;
        s_axis_tvalid <= 1'b1;
        accepted = 1'b0;
        while (!accepted) begin
            @(negedge i_clk);
            accepted = s_axis_tready;
            @(posedge i_clk);
        end
        predict_scan_bytes(ev);
    endtask

    // Stop offering requests and wait until every expected byte has come out.
    task automatic drain_scan_bytes();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_scan_q.size() != 0);
    endtask

    // Change the receiver's behavior between clock edges so it sees a stable value.
    task automatic set_receiver_gaps(input bit on);
        @(negedge i_clk);
        recv_gaps = on;
        @(posedge i_clk);
    endtask

    task automatic test_range_and_nomap();
        send_key_event(key_event(1'b0, 8'h00, 0, 0, 0, 0, 0));
        send_key_event(key_event(1'b1, 8'h66, 1, 1, 1, 1, 1));
        send_key_event(key_event(1'b0, 8'hE8, 0, 0, 0, 0, 0));
        send_key_event(key_event(1'b1, 8'hFF, 1, 1, 1, 1, 1));
        drain_scan_bytes();
    endtask

    task automatic test_plain_and_extended();
        send_key_event(key_event(1'b0, 8'h04, 1, 1, 1, 1, 1));
        send_key_event(key_event(1'b1, 8'h04, 0, 0, 0, 0, 0));
        send_key_event(key_event(1'b0, 8'h58, 0, 1, 0, 1, 0));
        send_key_event(key_event(1'b1, 8'hE7, 1, 0, 1, 0, 1));
        drain_scan_bytes();
    endtask

    task automatic test_print_screen();
        send_key_event(key_event(1'b0, 8'h46, 0, 0, 1, 0, 0));
        send_key_event(key_event(1'b1, 8'h9A, 1, 1, 1, 0, 0));
        send_key_event(key_event(1'b0, 8'h46, 1, 0, 0, 0, 0));
        send_key_event(key_event(1'b1, 8'h46, 0, 1, 0, 1, 1));
        send_key_event(key_event(1'b0, 8'h9A, 0, 0, 0, 1, 1));
        send_key_event(key_event(1'b1, 8'h46, 0, 0, 0, 0, 0));
        drain_scan_bytes();
    endtask

    task automatic test_navigation_prefixes();
        send_key_event(key_event(1'b0, 8'h49, 0, 1, 0, 0, 0));
        send_key_event(key_event(1'b0, 8'h54, 0, 0, 0, 1, 0));
        send_key_event(key_event(1'b0, 8'h52, 0, 1, 0, 0, 1));
        send_key_event(key_event(1'b1, 8'h4F, 0, 1, 0, 0, 0));
        send_key_event(key_event(1'b1, 8'h54, 0, 0, 0, 1, 1));
        send_key_event(key_event(1'b1, 8'h4A, 1, 1, 1, 1, 0));
        drain_scan_bytes();
    endtask

    task automatic test_pause();
        send_key_event(key_event(1'b0, 8'h48, 1, 0, 0, 0, 0));
        send_key_event(key_event(1'b0, 8'h48, 0, 1, 1, 1, 1));
        send_key_event(key_event(1'b1, 8'h48, 1, 1, 1, 1, 1));
        drain_scan_bytes();
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_stall();
        send_gaps = 1'b0;
        @(negedge i_clk);
        holdoff_trigger = holdoff_trigger + 1;
        @(posedge i_clk);
        repeat (24) send_key_event(random_key_event());
        drain_scan_bytes();
        send_gaps = 1'b1;
    endtask

    // Back-to-back requests with the output always ready.
    task automatic test_streaming_no_gaps();
        send_gaps = 1'b0;
        set_receiver_gaps(1'b0);
        repeat (80) send_key_event(random_key_event());
        drain_scan_bytes();
        set_receiver_gaps(1'b1);
        send_gaps = 1'b1;
    endtask

    task automatic test_random_events(input int count);
        repeat (count) send_key_event(random_key_event());
        drain_scan_bytes();
    endtask

    // Output ready: a long hold-off on request, otherwise random gaps.
    always @(posedge i_clk) begin : receiver
        int holdoff_left;
        int holdoff_seen;
        if (holdoff_trigger != holdoff_seen) begin
            holdoff_seen = holdoff_trigger;
            holdoff_left = 300;
        end
        if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            m_axis_tready <= 1'b0;
        end else if (recv_gaps && $urandom_range(99) < 28) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each byte that leaves the block with the oldest expected one.
    always @(negedge i_clk) begin
        t_scan_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_scan_q.size() == 0) begin
                $error("unexpected scan byte %02h status %0d last %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_count++;
            end else begin
                exp_res = expected_scan_q.pop_front();
                if (m_axis_tdata !== exp_res.scan_byte) begin
                    $error("scan_byte: expected %02h, got %02h", exp_res.scan_byte, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== exp_res.last_byte) begin
                    $error("last_byte: expected %0b, got %0b", exp_res.last_byte, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Run the tests in turn, then report.
    initial begin
        load_usage_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_range_and_nomap();
        test_plain_and_extended();
        test_print_screen();
        test_navigation_prefixes();
        test_pause();
        test_output_stall();
        test_streaming_no_gaps();
        test_random_events(400);
        repeat (16) @(posedge i_clk);
        if (error_count == 0 && expected_scan_q.size() == 0) begin
            $display("hid_usage_to_ps2_set2_scancode verification clean");
        end else begin
            $display("hid_usage_to_ps2_set2_scancode verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20000000;
        $display("hid_usage_to_ps2_set2_scancode verification failed");
        $finish;
    end

endmodule
